// ----- design/ertml_pkg.sv -----
// ----------------------------------------------------------------------------
// ertml_pkg: shared constants and types of the echo range trimmed mean level
// Sample batch geometry, distance conversion constants, divider widths and
// the request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package ertml_pkg;

   localparam int SAMPLES  = 10;
   localparam int TRIM     = 2;
   localparam int TRIM_EFF = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
   localparam int KEPT     = SAMPLES - 2 * TRIM_EFF;

   localparam int ECHO_W = 20;
   localparam int DIST_W = 16;
   localparam int CM_W   = 8;
   localparam int PCT_W  = 7;

   localparam int CM_SCALE   = 10;
   localparam int CM_DIVISOR = 291;
   localparam int CM_LIMIT   = 200;
   localparam int CONV_LIMIT = CM_LIMIT * CM_DIVISOR;
   localparam int PCT_FULL   = 100;

   localparam int IDX_W  = $clog2(SAMPLES);
   localparam int SUM_W  = $clog2(SAMPLES * CM_LIMIT);
   localparam int PROD_W = ECHO_W + 3;
   localparam int DIFF_W = DIST_W + 1;
   localparam int NUM_W  = DIFF_W + 7;

   localparam int DIV_NUM_W  = 22;
   localparam int DIV_DEN_W  = 16;
   localparam int DIV_Q_W    = 8;
   localparam int DIV_STEP_W = $clog2(DIV_Q_W);
   localparam int DVS_W      = DIV_DEN_W + DIV_Q_W - 1;
   localparam int TOP_W      = DIV_DEN_W + DIV_Q_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FULL  = CSR_IDX_W'(1);

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- design/ertml_div.sv -----
// ----------------------------------------------------------------------------
// ertml_div: shared restoring divider
// One quotient bit per cycle, MSB first; the dividend must stay below
// divisor * 2**DIV_Q_W. A one-cycle done pulse marks the quotient.
// ----------------------------------------------------------------------------
module ertml_div import ertml_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_NUM_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [DIV_Q_W-1:0]    q_ff, q_in;
   logic [DVS_W-1:0]      rem_ext;
   logic [DVS_W-1:0]      rem_sub;
   logic                  ge;

   assign rem_ext = DVS_W'(rem_ff);
   assign ge      = rem_ext >= dvs_ff;
   assign rem_sub = rem_ext - dvs_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dvs_in  = DVS_W'(div_req.divisor) << (DIV_Q_W - 1);
         q_in    = '0;
         step_in = DIV_STEP_W'(DIV_Q_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_sub[DIV_NUM_W-1:0];
         end
         q_in    = {q_ff[DIV_Q_W-2:0], ge};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - DIV_STEP_W'(1);
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

// ----- design/echo_range_trimmed_mean_level.sv -----
// ----------------------------------------------------------------------------
// echo_range_trimmed_mean_level: ultrasonic range trimmed mean and fill level
// Converts echo durations to centimetres, keeps a batch of samples, sorts
// them, averages the middle ones and reports the tank fill percentage.
//
//   channel | ports                           | transfer
//   --------+---------------------------------+-------------------------------
//   request | start, busy, req_echo_duration  | edge with start high, busy low
//   result  | rsp_strobe, rsp_average_cm,     | edge ending the strobe cycle
//           | rsp_fill_percent                |
//   config  | csr_valid, csr_ready, csr_index,| edge with csr_valid, csr_ready
//           | csr_data                        |
//
// An in-range sample holds busy through one setup state, eight divider steps
// and one store; an out-of-range echo skips the divider and is stored at setup.
// The sample that closes a batch adds bubble-sort passes on one comparator,
// a summing pass, the mean division and the fill step, whose division is
// skipped when the fill percentage needs none. The result strobe comes with
// busy low.
// Reset is synchronous and clears count, sequencer and distance registers.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module echo_range_trimmed_mean_level import ertml_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ECHO_W-1:0]    req_echo_duration,
   output logic                 rsp_strobe,
   output logic [CM_W-1:0]      rsp_average_cm,
   output logic [PCT_W-1:0]     rsp_fill_percent,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_data
);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_CONV       = 4'd1;
   localparam logic [3:0] ST_CONV_WAIT  = 4'd2;
   localparam logic [3:0] ST_SORT       = 4'd3;
   localparam logic [3:0] ST_SUM        = 4'd4;
   localparam logic [3:0] ST_MEAN       = 4'd5;
   localparam logic [3:0] ST_MEAN_WAIT  = 4'd6;
   localparam logic [3:0] ST_FILL_PREP  = 4'd7;
   localparam logic [3:0] ST_FILL_CHECK = 4'd8;
   localparam logic [3:0] ST_FILL_WAIT  = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         pass_ff, pass_in;
   logic                     strobe_ff, strobe_in;
   logic signed [DIST_W-1:0] empty_ff, empty_in;
   logic signed [DIST_W-1:0] full_ff, full_in;

   logic [PROD_W-1:0]        x_ff, x_in;
   logic [SUM_W-1:0]         acc_ff, acc_in;
   logic [CM_W-1:0]          avg_ff, avg_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic [DIV_DEN_W-1:0]     den_ff, den_in;
   logic                     den_zero_ff, den_zero_in;
   logic [PCT_W-1:0]         pct_ff, pct_in;
   logic [CM_W-1:0]          smp_ff [SAMPLES];
   logic [CM_W-1:0]          smp_in [SAMPLES];

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic                     shift_en;
   logic                     shift_swap;
   logic                     shift_load;
   logic                     store_go;
   logic [CM_W-1:0]          cm_val;
   logic [CM_W-1:0]          smp_lo;
   logic [CM_W-1:0]          smp_hi;
   logic [CM_W-1:0]          tail_val;
   logic                     in_keep;
   logic [ECHO_W-2:0]        half;
   logic signed [DIFF_W-1:0] diff_s;
   logic signed [DIFF_W-1:0] den_s;
   logic [DIFF_W-1:0]        den_mag;
   logic signed [NUM_W-1:0]  diff_x;
   logic signed [NUM_W-1:0]  num_raw;
   logic [TOP_W-1:0]         den_top;
   logic signed [DIST_W-1:0] avg_s;

   ertml_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   assign half    = req_echo_duration[ECHO_W-1:1];
   assign smp_lo  = (smp_ff[0] > smp_ff[1]) ? smp_ff[1] : smp_ff[0];
   assign smp_hi  = (smp_ff[0] > smp_ff[1]) ? smp_ff[0] : smp_ff[1];
   assign in_keep = ({1'b0, pos_ff} >= (IDX_W + 1)'(TRIM_EFF)) &&
                    ({1'b0, pos_ff} < (IDX_W + 1)'(SAMPLES - TRIM_EFF));

   assign diff_s  = DIFF_W'(empty_ff) - $signed(DIFF_W'({1'b0, avg_ff}));
   assign den_s   = DIFF_W'(empty_ff) - DIFF_W'(full_ff);
   assign den_mag = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);
   assign diff_x  = NUM_W'(diff_s);
   assign num_raw = diff_x * $signed(NUM_W'(PCT_FULL));
   assign den_top = {den_ff, {DIV_Q_W{1'b0}}};
   assign avg_s   = $signed({{(DIST_W - CM_W){1'b0}}, avg_ff});

   always_comb begin
      empty_in = empty_ff;
      full_in  = full_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EMPTY: empty_in = $signed(csr_data);
            CSR_FULL:  full_in  = $signed(csr_data);
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      pass_in     = pass_ff;
      strobe_in   = 1'b0;
      x_in        = x_ff;
      acc_in      = acc_ff;
      avg_in      = avg_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      den_zero_in = den_zero_ff;
      pct_in      = pct_ff;
      shift_en    = 1'b0;
      shift_swap  = 1'b0;
      shift_load  = 1'b0;
      store_go    = 1'b0;
      cm_val      = '0;
      div_req     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = PROD_W'(half) * PROD_W'(CM_SCALE);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (x_ff >= PROD_W'(CONV_LIMIT)) begin
               store_go = 1'b1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = x_ff[DIV_NUM_W-1:0];
               div_req.divisor  = DIV_DEN_W'(CM_DIVISOR);
               state_in         = ST_CONV_WAIT;
            end
         end
         ST_CONV_WAIT: begin
            if (div_rsp.done) begin
               store_go = 1'b1;
               cm_val   = div_rsp.quotient[CM_W-1:0];
            end
         end
         ST_SORT: begin
            shift_en   = 1'b1;
            shift_swap = pos_ff != IDX_W'(SAMPLES - 1);
            pos_in     = pos_ff + IDX_W'(1);
            if (pos_ff == IDX_W'(SAMPLES - 1)) begin
               pos_in  = '0;
               pass_in = pass_ff + IDX_W'(1);
               if (pass_ff == IDX_W'(SAMPLES - 2)) begin
                  acc_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            shift_en = 1'b1;
            pos_in   = pos_ff + IDX_W'(1);
            if (in_keep) begin
               acc_in = acc_ff + SUM_W'(smp_ff[0]);
            end
            if (pos_ff == IDX_W'(SAMPLES - 1)) begin
               pos_in   = '0;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(acc_ff);
            div_req.divisor  = DIV_DEN_W'(KEPT);
            state_in         = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[CM_W-1:0];
               state_in = ST_FILL_PREP;
            end
         end
         ST_FILL_PREP: begin
            num_in      = den_s[DIFF_W-1] ? -num_raw : num_raw;
            den_in      = den_mag[DIV_DEN_W-1:0];
            den_zero_in = den_s == '0;
            state_in    = ST_FILL_CHECK;
         end
         ST_FILL_CHECK: begin
            priority if (den_zero_ff) begin
               pct_in    = (avg_s <= full_ff) ? PCT_W'(PCT_FULL) : '0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (num_ff <= 0) begin
               pct_in    = '0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (TOP_W'($unsigned(num_ff)) >= den_top) begin
               pct_in    = PCT_W'(PCT_FULL);
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = num_ff[DIV_NUM_W-1:0];
               div_req.divisor  = den_ff;
               state_in         = ST_FILL_WAIT;
            end
         end
         ST_FILL_WAIT: begin
            if (div_rsp.done) begin
               pct_in    = (div_rsp.quotient > DIV_Q_W'(PCT_FULL)) ?
                           PCT_W'(PCT_FULL) : div_rsp.quotient[PCT_W-1:0];
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (store_go) begin
         shift_en   = 1'b1;
         shift_load = 1'b1;
         if (cnt_ff == IDX_W'(SAMPLES - 1)) begin
            cnt_in   = '0;
            pos_in   = '0;
            pass_in  = '0;
            state_in = ST_SORT;
         end else begin
            cnt_in   = cnt_ff + IDX_W'(1);
            state_in = ST_IDLE;
         end
      end
   end

   always_comb begin
      priority if (shift_load) begin
         tail_val = cm_val;
      end else if (shift_swap) begin
         tail_val = smp_lo;
      end else begin
         tail_val = smp_ff[0];
      end
      smp_in = smp_ff;
      if (shift_en) begin
         for (int i = 0; i < SAMPLES - 1; i++) begin
            smp_in[i] = smp_ff[i+1];
         end
         smp_in[SAMPLES-1] = tail_val;
         if (shift_swap) begin
            smp_in[0] = smp_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         pass_ff   <= '0;
         strobe_ff <= 1'b0;
         empty_ff  <= '0;
         full_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         pass_ff   <= pass_in;
         strobe_ff <= strobe_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      avg_ff      <= avg_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      pct_ff      <= pct_in;
      smp_ff      <= smp_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_average_cm   = avg_ff;
   assign rsp_fill_percent = pct_ff;

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_fill_percent <= PCT_W'(PCT_FULL)) &&
                     (rsp_average_cm < CM_W'(CM_LIMIT)))
      else $error("result field out of range");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_CONV_WAIT) || (state_ff == ST_MEAN_WAIT) ||
                       (state_ff == ST_FILL_WAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule
